// ----- rtl/vfpf_pkg.sv -----
package vfpf_pkg;

    localparam int TABLE_ENTRIES = 4096;
    localparam int PROBE_LIMIT   = 8;
    localparam int PROBE_SLOTS   = (PROBE_LIMIT < TABLE_ENTRIES) ? PROBE_LIMIT : TABLE_ENTRIES;
    localparam int PROBE_CNT_W   = (PROBE_SLOTS > 1) ? $clog2(PROBE_SLOTS) : 1;
    localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
    localparam int IDX_W         = 16;
    localparam int KEY_W         = 3 * IDX_W;
    localparam int EPOCH_W       = 8;
    localparam int ENTRY_W       = EPOCH_W + KEY_W;
    localparam int COORD_W       = 32;
    localparam int TAG_W         = 32;
    localparam int COUNT_W       = 24;
    localparam int S_DATA_W      = 3 * COORD_W + TAG_W;
    localparam int M_DATA_W      = 3 * COORD_W + TAG_W + COUNT_W;
    localparam int M_USER_W      = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic KIND_POINT   = 1'b0;
    localparam logic KIND_EOF     = 1'b1;
    localparam logic KIND_KEPT    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_INDEX,
        ST_HASH,
        ST_READ,
        ST_CHECK,
        ST_EMIT,
        ST_EMIT_FULL,
        ST_SUMMARY
    } vfpf_state_t;

    typedef struct packed {
        logic capture;
        logic mul_en;
        logic idx_en;
        logic hash_en;
        logic probe_step;
        logic key_wr;
        logic clr_start;
        logic clr_wr;
        logic emit_pt;
        logic emit_full;
        logic emit_sum;
    } vfpf_cmd_t;

    typedef struct packed {
        logic in_eof;
        logic slot_free;
        logic key_hit;
        logic probe_last;
        logic out_free;
        logic clr_last;
        logic epoch_wrap;
    } vfpf_sts_t;

endpackage

// ----- rtl/vfpf_ctrl.sv -----
module vfpf_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  vfpf_pkg::vfpf_sts_t sts,
    output vfpf_pkg::vfpf_cmd_t cmd
);

    vfpf_pkg::vfpf_state_t state_reg;
    vfpf_pkg::vfpf_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= vfpf_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            vfpf_pkg::ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last) begin
                    state_next = vfpf_pkg::ST_IDLE;
                end
            end
            vfpf_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = sts.in_eof ? vfpf_pkg::ST_SUMMARY : vfpf_pkg::ST_MUL;
                end
            end
            vfpf_pkg::ST_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = vfpf_pkg::ST_INDEX;
            end
            vfpf_pkg::ST_INDEX: begin
                cmd.idx_en = 1'b1;
                state_next = vfpf_pkg::ST_HASH;
            end
            vfpf_pkg::ST_HASH: begin
                cmd.hash_en = 1'b1;
                state_next  = vfpf_pkg::ST_READ;
            end
            vfpf_pkg::ST_READ: begin
                state_next = vfpf_pkg::ST_CHECK;
            end
            vfpf_pkg::ST_CHECK: begin
                if (sts.slot_free) begin
                    cmd.key_wr = 1'b1;
                    state_next = vfpf_pkg::ST_EMIT;
                end else if (sts.key_hit) begin
                    state_next = vfpf_pkg::ST_IDLE;
                end else if (sts.probe_last) begin
                    state_next = vfpf_pkg::ST_EMIT_FULL;
                end else begin
                    cmd.probe_step = 1'b1;
                    state_next     = vfpf_pkg::ST_READ;
                end
            end
            vfpf_pkg::ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit_pt = 1'b1;
                    state_next  = vfpf_pkg::ST_IDLE;
                end
            end
            vfpf_pkg::ST_EMIT_FULL: begin
                if (sts.out_free) begin
                    cmd.emit_pt   = 1'b1;
                    cmd.emit_full = 1'b1;
                    state_next    = vfpf_pkg::ST_IDLE;
                end
            end
            vfpf_pkg::ST_SUMMARY: begin
                if (sts.out_free) begin
                    cmd.emit_sum = 1'b1;
                    if (sts.epoch_wrap) begin
                        cmd.clr_start = 1'b1;
                        state_next    = vfpf_pkg::ST_CLEAR;
                    end else begin
                        state_next = vfpf_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = vfpf_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

// ----- rtl/vfpf_dp.sv -----
module vfpf_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [vfpf_pkg::S_DATA_W-1:0]       s_tdata,
    input  logic                                s_tuser,
    input  logic                                cfg_valid,
    input  logic [31:0]                         cfg_data,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [vfpf_pkg::M_DATA_W-1:0]       m_tdata,
    output logic [vfpf_pkg::M_USER_W-1:0]       m_tuser,
    input  vfpf_pkg::vfpf_cmd_t                 cmd,
    output vfpf_pkg::vfpf_sts_t                 sts
);

    localparam logic [31:0] PRIME_X = 32'd73856093;
    localparam logic [31:0] PRIME_Y = 32'd19349663;
    localparam logic [31:0] PRIME_Z = 32'd83492791;
    localparam int M_DATA_LOW_W = 3 * vfpf_pkg::COORD_W + vfpf_pkg::TAG_W;

    logic [31:0]                         inv_voxel_size_reg;
    logic [2:0][vfpf_pkg::COORD_W-1:0]   coord_reg;
    logic [vfpf_pkg::TAG_W-1:0]          tag_reg;
    logic [2:0][31:0]                    mag_reg;
    logic [2:0]                          neg_reg;
    logic [2:0][31:0]                    q_reg;
    logic [2:0][vfpf_pkg::IDX_W-1:0]     idx_reg;
    logic [vfpf_pkg::KEY_W-1:0]          key_reg;
    logic [vfpf_pkg::ADDR_W-1:0]         slot_reg;
    logic [vfpf_pkg::PROBE_CNT_W-1:0]    probe_cnt_reg;
    logic [vfpf_pkg::EPOCH_W-1:0]        epoch_reg;
    logic [vfpf_pkg::ADDR_W-1:0]         clr_addr_reg;
    logic [vfpf_pkg::ENTRY_W-1:0]        rd_data_reg;
    logic [vfpf_pkg::COUNT_W-1:0]        kept_count_reg;
    logic                                overflow_reg;
    logic                                m_tvalid_reg;
    logic [vfpf_pkg::M_DATA_W-1:0]       m_tdata_reg;
    logic [vfpf_pkg::M_USER_W-1:0]       m_tuser_reg;

    logic [vfpf_pkg::ENTRY_W-1:0]        table_mem [vfpf_pkg::TABLE_ENTRIES];

    logic [2:0][31:0]                    mag_next;
    logic [2:0][vfpf_pkg::IDX_W-1:0]     idx_next;
    logic [2:0][31:0]                    hprod;
    logic [31:0]                         hash;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            mag_next[a] = s_tdata[a*32+31] ? (~s_tdata[a*32 +: 32] + 32'd1)
                                           : s_tdata[a*32 +: 32];
            if (neg_reg[a]) begin
                idx_next[a] = (q_reg[a] > 32'd32768) ? 16'h8000 : (16'd0 - q_reg[a][15:0]);
            end else begin
                idx_next[a] = (q_reg[a] > 32'd32767) ? 16'h7fff : q_reg[a][15:0];
            end
        end
        hprod[0] = {{16{idx_reg[0][15]}}, idx_reg[0]} * PRIME_X;
        hprod[1] = {{16{idx_reg[1][15]}}, idx_reg[1]} * PRIME_Y;
        hprod[2] = {{16{idx_reg[2][15]}}, idx_reg[2]} * PRIME_Z;
        hash     = hprod[0] ^ hprod[1] ^ hprod[2];
    end

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_voxel_size_reg <= 32'd65536;
        end else if (cfg_valid) begin
            inv_voxel_size_reg <= cfg_data;
        end
    end

    // voxel index pipeline
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            coord_reg <= s_tdata[3*vfpf_pkg::COORD_W-1:0];
            tag_reg   <= s_tdata[vfpf_pkg::S_DATA_W-1 -: vfpf_pkg::TAG_W];
            mag_reg   <= mag_next;
            for (int a = 0; a < 3; a++) begin
                neg_reg[a] <= s_tdata[a*32+31];
            end
        end
        if (cmd.mul_en) begin
            for (int a = 0; a < 3; a++) begin
                q_reg[a] <= 32'((64'(mag_reg[a]) * 64'(inv_voxel_size_reg)) >> 32);
            end
        end
        if (cmd.idx_en) begin
            idx_reg <= idx_next;
        end
        if (cmd.hash_en) begin
            key_reg <= {idx_reg[0], idx_reg[1], idx_reg[2]};
        end
    end

    // probe address and frame epoch
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg      <= '0;
            probe_cnt_reg <= '0;
            epoch_reg     <= vfpf_pkg::EPOCH_W'(1);
            clr_addr_reg  <= '0;
        end else begin
            if (cmd.hash_en) begin
                slot_reg      <= hash[vfpf_pkg::ADDR_W-1:0];
                probe_cnt_reg <= '0;
            end else if (cmd.probe_step) begin
                slot_reg      <= slot_reg + vfpf_pkg::ADDR_W'(1);
                probe_cnt_reg <= probe_cnt_reg + vfpf_pkg::PROBE_CNT_W'(1);
            end
            if (cmd.emit_sum) begin
                epoch_reg <= sts.epoch_wrap ? vfpf_pkg::EPOCH_W'(1)
                                            : epoch_reg + vfpf_pkg::EPOCH_W'(1);
            end
            if (cmd.clr_start) begin
                clr_addr_reg <= '0;
            end else if (cmd.clr_wr) begin
                clr_addr_reg <= clr_addr_reg + vfpf_pkg::ADDR_W'(1);
            end
        end
    end

    // key table, entry is {epoch, key}
    always_ff @(posedge aclk) begin
        if (cmd.key_wr) begin
            table_mem[slot_reg] <= {epoch_reg, key_reg};
        end else if (cmd.clr_wr) begin
            table_mem[clr_addr_reg] <= '0;
        end
        rd_data_reg <= table_mem[slot_reg];
    end

    // frame counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kept_count_reg <= '0;
            overflow_reg   <= 1'b0;
        end else if (cmd.emit_sum) begin
            kept_count_reg <= '0;
            overflow_reg   <= 1'b0;
        end else if (cmd.emit_pt) begin
            if (kept_count_reg != vfpf_pkg::COUNT_MAX) begin
                kept_count_reg <= kept_count_reg + vfpf_pkg::COUNT_W'(1);
            end
            overflow_reg <= overflow_reg | cmd.emit_full;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit_pt || cmd.emit_sum) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_pt) begin
            m_tdata_reg <= {vfpf_pkg::COUNT_W'(0), tag_reg, coord_reg};
            m_tuser_reg <= {cmd.emit_full, vfpf_pkg::KIND_KEPT};
        end else if (cmd.emit_sum) begin
            m_tdata_reg <= {kept_count_reg, (M_DATA_LOW_W)'(0)};
            m_tuser_reg <= {overflow_reg, vfpf_pkg::KIND_SUMMARY};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign sts.in_eof     = (s_tuser == vfpf_pkg::KIND_EOF);
    assign sts.slot_free  = (rd_data_reg[vfpf_pkg::ENTRY_W-1 -: vfpf_pkg::EPOCH_W] != epoch_reg);
    assign sts.key_hit    = (rd_data_reg[vfpf_pkg::KEY_W-1:0] == key_reg);
    assign sts.probe_last = (probe_cnt_reg == vfpf_pkg::PROBE_CNT_W'(vfpf_pkg::PROBE_SLOTS - 1));
    assign sts.out_free   = !m_tvalid_reg || m_tready;
    assign sts.clr_last   = (clr_addr_reg == vfpf_pkg::ADDR_W'(vfpf_pkg::TABLE_ENTRIES - 1));
    assign sts.epoch_wrap = (epoch_reg == '1);

endmodule

// ----- rtl/voxel_first_point_filter.sv -----
// kept point: after acceptance it passes MUL, INDEX, HASH, READ, CHECK and EMIT states; each further
// probe repeats READ and CHECK (up to 8 probes); a dropped point returns to IDLE from CHECK
// throughput: one item at a time, set by the read-compare loop on the single key table
// end of frame: summary word loaded from the SUMMARY state; every 255th frame adds a key table sweep
// reset: synchronous active-low; the whole key table is swept before s_tready rises
// the configuration channel is always ready
module voxel_first_point_filter (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [vfpf_pkg::S_DATA_W-1:0]     s_tdata,  // x, y, z, point_tag
    input  logic                              s_tuser,  // kind
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [vfpf_pkg::M_DATA_W-1:0]     m_tdata,  // out_x, out_y, out_z, out_tag, kept_count
    output logic [vfpf_pkg::M_USER_W-1:0]     m_tuser,  // result_kind, table_full
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [31:0]                       cfg_data
);

    vfpf_pkg::vfpf_cmd_t cmd;
    vfpf_pkg::vfpf_sts_t sts;

    assign cfg_ready = 1'b1;

    vfpf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    vfpf_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .sts       (sts)
    );

    a_key_wr_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.key_wr |-> sts.slot_free && !cmd.clr_wr)
        else $error("key written to an occupied slot or during sweep");

    a_emit_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_pt || cmd.emit_sum) |-> sts.out_free && !(cmd.emit_pt && cmd.emit_sum))
        else $error("result loaded over an untaken word");

    a_summary_zero_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] == vfpf_pkg::KIND_SUMMARY |->
            m_tdata[3*vfpf_pkg::COORD_W+vfpf_pkg::TAG_W-1:0] == '0)
        else $error("summary word carries point payload");

    a_wrap_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_sum && sts.epoch_wrap |=> !s_tready)
        else $error("input taken while the key table is swept");

endmodule
